/* hdl/pidaw_pkg.sv */
// Shared types, codes and helpers for the anti-windup PID controller.
`default_nettype none
package pidaw_pkg;

  localparam int unsigned DW      = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned QUOT_W  = 47;

  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_I   = 3'd1;
  localparam logic [2:0] REG_GAIN_D   = 3'd2;
  localparam logic [2:0] REG_ILIM     = 3'd3;
  localparam logic [2:0] REG_OUT_MIN  = 3'd4;
  localparam logic [2:0] REG_OUT_MAX  = 3'd5;
  localparam logic [2:0] REG_SP_LIM   = 3'd6;
  localparam logic [2:0] REG_BLEND    = 3'd7;

  localparam logic [2:0] MUL_P  = 3'd0;
  localparam logic [2:0] MUL_D  = 3'd1;
  localparam logic [2:0] MUL_IL = 3'd2;
  localparam logic [2:0] MUL_IH = 3'd3;
  localparam logic [2:0] MUL_B1 = 3'd4;
  localparam logic [2:0] MUL_B2 = 3'd5;

  typedef struct packed {
    logic       ld_in;
    logic       ld_err;
    logic [2:0] mul_sel;
    logic       cap_p;
    logic       cap_d;
    logic       cap_ilo;
    logic       cap_ihi;
    logic       ld_i;
    logic       ld_sum;
    logic       ld_acc;
    logic       cap_b1;
    logic       cap_b2;
    logic       ld_blend;
    logic       ld_out;
  } pidaw_cmd_t;

  typedef struct packed {
    logic mode;
    logic div_done;
    logic blend_on;
  } pidaw_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/pidaw_div.sv */
// Restoring divider for the accumulator bound, one quotient bit per cycle.
`default_nettype none
module pidaw_div
  import pidaw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [QUOT_W-1:0]   dividend,
  input  wire logic [DW-1:0]       divisor,
  output logic      [QUOT_W-1:0]   quot,
  output logic                     done
);

  logic [QUOT_W-1:0] num_r, num_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     dvs_r;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [DW:0]       trial;
  logic [DW:0]       diff;

  assign trial = {rem_r, num_r[QUOT_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'(QUOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DW-1:0];
        num_nxt = {num_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        num_nxt = {num_r[QUOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quot = num_r;
  assign done = ~busy_r;

endmodule
`default_nettype wire

/* hdl/pidaw_ctrl.sv */
// Sequencer for the PID step and the result handshake.
`default_nettype none
module pidaw_ctrl
  import pidaw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire pidaw_sts_t sts,
  output pidaw_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_MP    = 4'd2;
  localparam logic [3:0] S_MD    = 4'd3;
  localparam logic [3:0] S_MIL   = 4'd4;
  localparam logic [3:0] S_MIH   = 4'd5;
  localparam logic [3:0] S_ITERM = 4'd6;
  localparam logic [3:0] S_ILIM  = 4'd7;
  localparam logic [3:0] S_SUM   = 4'd8;
  localparam logic [3:0] S_WDIV  = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_B1    = 4'd11;
  localparam logic [3:0] S_B2    = 4'd12;
  localparam logic [3:0] S_B3    = 4'd13;
  localparam logic [3:0] S_BL    = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_free  = ~ovalid_r | out_ready;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_P;
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r & ~out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        if (sts.mode) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ld_err = 1'b1;
          state_nxt  = S_MP;
        end
      end
      S_MP: begin
        cmd.mul_sel = MUL_P;
        state_nxt   = S_MD;
      end
      S_MD: begin
        cmd.cap_p   = 1'b1;
        cmd.mul_sel = MUL_D;
        state_nxt   = S_MIL;
      end
      S_MIL: begin
        cmd.cap_d   = 1'b1;
        cmd.mul_sel = MUL_IL;
        state_nxt   = S_MIH;
      end
      S_MIH: begin
        cmd.cap_ilo = 1'b1;
        cmd.mul_sel = MUL_IH;
        state_nxt   = S_ITERM;
      end
      S_ITERM: begin
        cmd.cap_ihi = 1'b1;
        state_nxt   = S_ILIM;
      end
      S_ILIM: begin
        cmd.ld_i  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.ld_sum = 1'b1;
        state_nxt  = S_WDIV;
      end
      S_WDIV: begin
        if (sts.div_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.ld_acc = 1'b1;
        state_nxt  = sts.blend_on ? S_B1 : S_DONE;
      end
      S_B1: begin
        cmd.mul_sel = MUL_B1;
        state_nxt   = S_B2;
      end
      S_B2: begin
        cmd.cap_b1  = 1'b1;
        cmd.mul_sel = MUL_B2;
        state_nxt   = S_B3;
      end
      S_B3: begin
        cmd.cap_b2 = 1'b1;
        state_nxt  = S_BL;
      end
      S_BL: begin
        cmd.ld_blend = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/pidaw_dp.sv */
// Datapath: config registers, shared multiplier, loop state and result registers.
`default_nettype none
module pidaw_dp
  import pidaw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [DW-1:0]     cfg_data,
  input  wire logic              in_mode,
  input  wire logic [DW-1:0]     in_measured,
  input  wire logic [DW-1:0]     in_target,
  output logic      [DW-1:0]     out_drive,
  output logic      [DW-1:0]     out_error_now,
  input  wire pidaw_cmd_t        cmd,
  output pidaw_sts_t             sts
);

  logic signed [31:0] gp_r, gi_r, gd_r, omin_r, omax_r;
  logic        [30:0] ilim_r, slim_r;
  logic        [15:0] w_r;

  logic               mode_r;
  logic signed [31:0] meas_r, tgt_r;
  logic signed [31:0] err_r;
  logic signed [32:0] diff_r;
  logic signed [65:0] prod_r;
  logic signed [47:0] p_r;
  logic signed [48:0] d_r;
  logic signed [64:0] ilo_r;
  logic signed [47:0] ihi_r;
  logic signed [63:0] i_r;
  logic signed [65:0] sum_r;
  logic signed [31:0] res_r;
  logic signed [48:0] b1_r;
  logic signed [49:0] b2_r;
  logic signed [47:0] acc_r;
  logic signed [31:0] pmeas_r, pdrive_r;
  logic               first_r;
  logic [DW-1:0]      drive_r, errout_r;

  logic [QUOT_W-1:0]  quot;
  logic               div_done;
  logic [DW-1:0]      gi_mag;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r <= '0; gi_r <= '0; gd_r <= '0; ilim_r <= '0;
      omin_r <= '0; omax_r <= '0; slim_r <= '0; w_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:  gp_r   <= $signed(cfg_data);
        REG_GAIN_I:  gi_r   <= $signed(cfg_data);
        REG_GAIN_D:  gd_r   <= $signed(cfg_data);
        REG_ILIM:    ilim_r <= cfg_data[30:0];
        REG_OUT_MIN: omin_r <= $signed(cfg_data);
        REG_OUT_MAX: omax_r <= $signed(cfg_data);
        REG_SP_LIM:  slim_r <= cfg_data[30:0];
        REG_BLEND:   w_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign gi_mag = gi_r[31] ? (32'd0 - gi_r) : gi_r;

  pidaw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.ld_err),
    .dividend ({ilim_r, 16'd0}),
    .divisor  (gi_mag),
    .quot     (quot),
    .done     (div_done)
  );

  // error and derivative operand
  logic signed [32:0] tg33, lim33, sp33;
  logic signed [33:0] e34;
  always_comb begin
    tg33  = 33'(tgt_r);
    lim33 = $signed({2'b00, slim_r});
    sp33  = tg33;
    if (slim_r != '0) begin
      if (tg33 > lim33) begin
        sp33 = lim33;
      end else if (tg33 < -lim33) begin
        sp33 = -lim33;
      end
    end
    e34 = 34'(sp33) - 34'(meas_r);
  end

  // shared multiplier
  logic signed [32:0] opa, opb;
  logic        [16:0] wc;
  assign wc = 17'd65536 - {1'b0, w_r};
  always_comb begin
    case (cmd.mul_sel)
      MUL_P:  begin opa = 33'(gp_r);     opb = 33'(err_r); end
      MUL_D:  begin opa = 33'(gd_r);     opb = diff_r; end
      MUL_IL: begin opa = 33'(gi_r);     opb = $signed({1'b0, acc_r[31:0]}); end
      MUL_IH: begin opa = 33'(gi_r);     opb = 33'($signed(acc_r[47:32])); end
      MUL_B1: begin opa = 33'(pdrive_r); opb = $signed({17'd0, w_r}); end
      MUL_B2: begin opa = 33'(res_r);    opb = $signed({16'd0, wc}); end
      default: begin opa = 33'(gp_r);    opb = 33'(err_r); end
    endcase
  end

  // integral term
  logic signed [79:0] i_full;
  logic signed [63:0] i_sh, i_cl, ilim64;
  always_comb begin
    i_full = $signed({ihi_r, 32'd0}) + 80'(ilo_r);
    i_sh   = i_full[79:16];
    ilim64 = $signed({33'd0, ilim_r});
    i_cl   = i_sh;
    if (ilim_r != '0) begin
      if (i_sh > ilim64) begin
        i_cl = ilim64;
      end else if (i_sh < -ilim64) begin
        i_cl = -ilim64;
      end
    end
  end

  // accumulator update and output clamp
  logic               clamp_on, sat_hit;
  logic signed [48:0] t49, b49, acc49;
  logic signed [65:0] cs66, omin66, omax66;
  always_comb begin
    omin66   = 66'(omin_r);
    omax66   = 66'(omax_r);
    clamp_on = omin_r < omax_r;
    sat_hit  = clamp_on && !(sum_r > omin66 && sum_r < omax66);
    t49      = 49'(acc_r) + 49'(err_r);
    b49      = $signed({2'b00, quot});
    acc49    = t49;
    if (sat_hit) begin
      acc49 = 49'(err_r);
    end else if (ilim_r != '0 && gi_r != '0) begin
      if (t49 > b49) begin
        acc49 = b49;
      end else if (t49 < -b49) begin
        acc49 = -b49;
      end
    end else begin
      if (t49 > 49'sh0_7FFF_FFFF_FFFF) begin
        acc49 = 49'sh0_7FFF_FFFF_FFFF;
      end else if (t49 < -49'sh0_8000_0000_0000) begin
        acc49 = -49'sh0_8000_0000_0000;
      end
    end
    cs66 = sum_r;
    if (clamp_on) begin
      if (sum_r < omin66) begin
        cs66 = omin66;
      end else if (sum_r > omax66) begin
        cs66 = omax66;
      end
    end
  end

  logic signed [50:0] blend51;
  assign blend51 = 51'(b1_r) + 51'(b2_r);

  logic signed [47:0] p_new;
  assign p_new = prod_r[63:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      first_r  <= 1'b1;
      pmeas_r  <= '0;
      pdrive_r <= '0;
    end else begin
      if (cmd.ld_err) begin
        pmeas_r <= meas_r;
      end
      if (cmd.cap_p && first_r) begin
        pdrive_r <= sat32(66'(p_new));
        first_r  <= 1'b0;
      end
      if (cmd.ld_acc) begin
        acc_r <= acc49[47:0];
      end
      if (cmd.ld_out) begin
        if (mode_r) begin
          acc_r   <= '0;
          first_r <= 1'b1;
        end else begin
          pdrive_r <= res_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      mode_r <= in_mode;
      meas_r <= $signed(in_measured);
      tgt_r  <= $signed(in_target);
    end
    if (cmd.ld_err) begin
      err_r  <= sat32(66'(e34));
      diff_r <= first_r ? 33'sd0 : (33'(pmeas_r) - 33'(meas_r));
    end
    prod_r <= 66'(opa) * 66'(opb);
    if (cmd.cap_p)    p_r   <= p_new;
    if (cmd.cap_d)    d_r   <= prod_r[64:16];
    if (cmd.cap_ilo)  ilo_r <= prod_r[64:0];
    if (cmd.cap_ihi)  ihi_r <= prod_r[47:0];
    if (cmd.ld_i)     i_r   <= i_cl;
    if (cmd.ld_sum)   sum_r <= 66'(p_r) + 66'(i_r) + 66'(d_r);
    if (cmd.ld_acc)   res_r <= sat32(cs66);
    if (cmd.cap_b1)   b1_r  <= prod_r[48:0];
    if (cmd.cap_b2)   b2_r  <= prod_r[49:0];
    if (cmd.ld_blend) res_r <= blend51[47:16];
    if (cmd.ld_out) begin
      drive_r  <= mode_r ? '0 : res_r;
      errout_r <= mode_r ? '0 : err_r;
    end
  end

  assign out_drive     = drive_r;
  assign out_error_now = errout_r;

  assign sts.mode     = mode_r;
  assign sts.div_done = div_done;
  assign sts.blend_on = (w_r != '0);

endmodule
`default_nettype wire

/* hdl/pid_controller_antiwindup.sv */
// PID controller with integral clamp and anti-windup: top level.
// Sequence: a control item forms error, products and sum, waits on the 47-step
//   bound divider, then blends if enabled; a reset item (mode 1) goes to the result.
// Throughput: one item at a time; the next input is taken once the result is
//   registered, while that result still waits on out_ready.
// Reset: synchronous active-low; gains and limits clear, integrator clears,
//   first-step flag sets.
`default_nettype none
module pid_controller_antiwindup
  import pidaw_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [DW-1:0] cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_mode,
  input  wire logic [DW-1:0] in_measured,
  input  wire logic [DW-1:0] in_target,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [DW-1:0]      out_drive,
  output logic [DW-1:0]      out_error_now
);

  pidaw_cmd_t cmd;
  pidaw_sts_t sts;

  pidaw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidaw_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mode       (in_mode),
    .in_measured   (in_measured),
    .in_target     (in_target),
    .out_drive     (out_drive),
    .out_error_now (out_error_now),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
`default_nettype wire

/* hdl/pidaw_checker.sv */
// Port-level checker for the PID controller, bound to the top level.
`default_nettype none
module pidaw_checker
  import pidaw_pkg::*;
(
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [DW-1:0] out_drive,
  input wire logic [DW-1:0] out_error_now
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_error_now))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_drive     (out_drive),
  .out_error_now (out_error_now)
);
`default_nettype wire

/* tb/sv/pid_controller_antiwindup_checker.sv */
// Transfer monitor, PID step predictor and result comparison for the PID controller.
`timescale 1ns / 1ps
module pid_controller_antiwindup_checker
  import pidaw_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [DW-1:0] cfg_data,
  input  wire logic          in_valid,
  input  wire logic          in_ready,
  input  wire logic          in_mode,
  input  wire logic [DW-1:0] in_measured,
  input  wire logic [DW-1:0] in_target,
  input  wire logic          out_valid,
  input  wire logic          out_ready,
  input  wire logic [DW-1:0] out_drive,
  input  wire logic [DW-1:0] out_error_now,
  output int                 fail_count,
  output int                 pending
);

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic [31:0] drive;
    logic [31:0] err;
  } pid_result_t;

  logic signed [31:0] kp, ki, kd, omin, omax;
  logic [30:0] ilim, splim;
  logic [15:0] blend;
  longint last_meas, last_drive, accum;
  bit first_run;
  pid_result_t expected_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_word(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // floor(x*y / 2^16) with an exact 128-bit product
  function automatic longint qmul(longint x, longint y);
    logic signed [127:0] prod;
    prod = $signed(128'(x)) * $signed(128'(y));
    return longint'(prod >>> 16);
  endfunction

  function automatic pid_result_t pid_step(bit rst_item, logic [31:0] m_raw,
                                           logic [31:0] t_raw);
    pid_result_t r;
    longint meas, sp, err, p, d, it, sum, res, bnd, gimag;
    bit clamp_on;
    if (rst_item) begin
      accum = 0;
      first_run = 1;
      r = '0;
      return r;
    end
    clamp_on = omin < omax;
    meas = longint'($signed(m_raw));
    sp = longint'($signed(t_raw));
    if (splim != 0) sp = clip(sp, -longint'(splim), longint'(splim));
    err = sat_word(sp - meas);
    p = qmul(longint'(kp), err);
    if (first_run) begin
      last_meas = meas;
      last_drive = sat_word(p);
      first_run = 0;
    end
    d = qmul(longint'(kd), last_meas - meas);
    last_meas = meas;
    it = qmul(longint'(ki), accum);
    if (ilim != 0) it = clip(it, -longint'(ilim), longint'(ilim));
    sum = p + it + d;
    if (clamp_on && !(omin < sum && sum < omax)) begin
      accum = err;
    end else if (ilim != 0 && ki != 0) begin
      gimag = ki < 0 ? -longint'(ki) : longint'(ki);
      bnd = (longint'(ilim) <<< 16) / gimag;
      if (bnd > ACC_HI) bnd = ACC_HI;
      accum = clip(accum + err, -bnd, bnd);
    end else begin
      accum = clip(accum + err, ACC_LO, ACC_HI);
    end
    if (clamp_on) sum = clip(sum, longint'(omin), longint'(omax));
    res = sat_word(sum);
    if (blend != 0)
      res = qmul(last_drive * longint'(blend) + res * (65536 - longint'(blend)), 1);
    last_drive = res;
    r.drive = res[31:0];
    r.err = err[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pid_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      kp <= '0; ki <= '0; kd <= '0; ilim <= '0;
      omin <= '0; omax <= '0; splim <= '0; blend <= '0;
      last_meas = 0; last_drive = 0; accum = 0; first_run = 1;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:  kp <= cfg_data;
          REG_GAIN_I:  ki <= cfg_data;
          REG_GAIN_D:  kd <= cfg_data;
          REG_ILIM:    ilim <= cfg_data[30:0];
          REG_OUT_MIN: omin <= cfg_data;
          REG_OUT_MAX: omax <= cfg_data;
          REG_SP_LIM:  splim <= cfg_data[30:0];
          REG_BLEND:   blend <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(pid_step(in_mode, in_measured, in_target));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: drive %h error_now %h", out_drive, out_error_now);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (want.drive !== out_drive) begin
            $error("drive: expected %h actual %h", want.drive, out_drive);
            errs++;
          end
          if (want.err !== out_error_now) begin
            $error("error_now: expected %h actual %h", want.err, out_error_now);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/sv/pid_controller_antiwindup_test.sv */
// Stimulus and verdict for the PID controller: config phases, directed and random steps.
`timescale 1ns / 1ps
module pid_controller_antiwindup_test
  import pidaw_pkg::*;
;
  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;
  logic in_valid = 0, in_mode = 0, out_ready = 0;
  logic [DW-1:0] in_measured = '0, in_target = '0;
  logic in_ready, out_valid;
  logic [DW-1:0] out_drive, out_error_now;
  int fail_count, pending, sent, idle_pct, stall_pct;

  always #10 clk = ~clk;

  pid_controller_antiwindup u_dut (.*);
  pid_controller_antiwindup_checker u_chk (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic send(bit mode, logic [31:0] m, logic [31:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_mode <= mode; in_measured <= m; in_target <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(32'h3_0000);
      3: return -$urandom_range(32'h3_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic set_all(logic [31:0] p, logic [31:0] i, logic [31:0] d, logic [30:0] il,
                         logic [31:0] lo, logic [31:0] hi, logic [30:0] sl, logic [15:0] b);
    write_reg(REG_GAIN_P, p); write_reg(REG_GAIN_I, i); write_reg(REG_GAIN_D, d);
    write_reg(REG_ILIM, il); write_reg(REG_OUT_MIN, lo); write_reg(REG_OUT_MAX, hi);
    write_reg(REG_SP_LIM, sl); write_reg(REG_BLEND, b);
    cfg_we <= 0;
  endtask

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    idle_pct = 0; stall_pct = 0; sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, both modes, clamps off then on
    send(0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(0, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    set_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 31'h0010_0000,
            32'hFFF0_0000, 32'h0010_0000, 31'h0008_0000, 16'h8000);
    send(0, 32'h0, 32'h0005_0000);
    send(0, 32'h0001_0000, 32'h7FFF_FFFF);
    send(0, 32'h8000_0000, 32'h0);
    send(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(0, 32'h0002_0000, 32'hFFFE_0000);
    send(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    for (int k = 0; k < 6; k++) send(k == 3, rnd_val(), rnd_val());
    drain();
    set_all(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 31'h1, 32'h5, 32'h5, 31'h1, 16'h1);
    for (int k = 0; k < 5; k++) send(0, rnd_val(), rnd_val());
    drain();
    // random phases under each idling mix
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 71; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 71; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      set_all($urandom_range(1) ? rnd_val() : $urandom_range(32'h2_0000),
              $urandom_range(1) ? rnd_val() : $urandom_range(32'h1_0000),
              $urandom_range(1) ? rnd_val() : $urandom_range(32'h1_0000),
              $urandom_range(3) == 0 ? 31'h0 : 31'($urandom),
              $urandom_range(1) ? -$urandom_range(32'h40_0000) : rnd_val(),
              $urandom_range(1) ? $urandom_range(32'h40_0000) : rnd_val(),
              $urandom_range(3) == 0 ? 31'h0 : 31'($urandom),
              $urandom_range(2) == 0 ? 16'h0 : 16'($urandom));
      for (int k = 0; k < 100; k++) begin
        send($urandom_range(19) == 0, rnd_val(), rnd_val());
        if (k == 50) drain();
      end
      drain();
    end
    $display("Covered %0d transfers across 16 register settings, including extreme gains,", sent);
    $display("disabled and degenerate clamps, reset items and four idle/stall mixes.");
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
